// ===== sv/gtc_pkg.sv =====
// Shared constants, codes and types of the touch gesture classifier.
package gtc_pkg;

   localparam int COORD_BITS = 12;
   localparam int SQ_BITS = 2 * COORD_BITS;
   localparam int SIZE_BITS = 13;
   localparam int DIST_BITS = 12;
   localparam int DIST_SQ_BITS = 2 * DIST_BITS;
   localparam int TIME_BITS = 16;
   localparam int CMP_BITS = (SQ_BITS + 3 > DIST_SQ_BITS + 1) ? SQ_BITS + 3 : DIST_SQ_BITS + 1;

   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((4 * COORD_BITS + 3 + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWIPE_MIN_DIST = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAG_MIN_DIST = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_MS = 3'd4;

   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET = 13'd240;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd240;
   localparam logic [DIST_BITS-1:0] SWIPE_MIN_RESET = 12'd80;
   localparam logic [DIST_BITS-1:0] DRAG_MIN_RESET = 12'd10;
   localparam logic [TIME_BITS-1:0] LONG_PRESS_RESET = 16'd400;
   localparam logic [DIST_SQ_BITS-1:0] SWIPE_SQ_RESET = 24'd6400;
   localparam logic [DIST_SQ_BITS-1:0] DRAG_SQ_RESET = 24'd100;

   typedef logic [CMP_BITS-1:0] cmp_type;
   typedef logic [RSP_DATA_BITS-1:0] rsp_data_type;

   typedef enum logic [1:0] {
      REQ_DOWN = 2'd0,
      REQ_MOVE = 2'd1,
      REQ_UP   = 2'd2,
      REQ_TICK = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_DOWN    = 3'd0,
      EV_LONG    = 3'd1,
      EV_CANCEL  = 3'd2,
      EV_MOVING  = 3'd3,
      EV_RELEASE = 3'd4,
      EV_TAP     = 3'd5
   } event_kind_type;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_UP    = 3'd3,
      DIR_DOWN  = 3'd4
   } swipe_dir_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]    screen_width;
      logic [SIZE_BITS-1:0]    screen_height;
      logic [DIST_SQ_BITS-1:0] swipe_sq;
      logic [DIST_SQ_BITS-1:0] drag_sq;
      logic [TIME_BITS-1:0]    long_press;
   } cfg_type;

   typedef struct packed {
      event_kind_type        kind;
      logic [COORD_BITS-1:0] from_x;
      logic [COORD_BITS-1:0] from_y;
      logic [COORD_BITS-1:0] to_x;
      logic [COORD_BITS-1:0] to_y;
      swipe_dir_type         dir;
      logic                  last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== sv/gtc_csr.sv =====
// Configuration registers of the gesture classifier, with registered squared distances.
module gtc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gtc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gtc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output gtc_pkg::cfg_type                    cfg
);

   logic [gtc_pkg::SIZE_BITS-1:0]    width_ff, width_in;
   logic [gtc_pkg::SIZE_BITS-1:0]    height_ff, height_in;
   logic [gtc_pkg::DIST_BITS-1:0]    swipe_min_ff, swipe_min_in;
   logic [gtc_pkg::DIST_BITS-1:0]    drag_min_ff, drag_min_in;
   logic [gtc_pkg::TIME_BITS-1:0]    long_press_ff, long_press_in;
   logic [gtc_pkg::DIST_SQ_BITS-1:0] swipe_sq_ff, swipe_sq_in;
   logic [gtc_pkg::DIST_SQ_BITS-1:0] drag_sq_ff, drag_sq_in;
   logic                             write;

   assign csr_ready = 1'b1;
   assign write = csr_valid & csr_ready;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      swipe_min_in = swipe_min_ff;
      drag_min_in = drag_min_ff;
      long_press_in = long_press_ff;
      if (write) begin
         case (csr_index)
            gtc_pkg::CSR_SCREEN_WIDTH: width_in = csr_data[gtc_pkg::SIZE_BITS-1:0];
            gtc_pkg::CSR_SCREEN_HEIGHT: height_in = csr_data[gtc_pkg::SIZE_BITS-1:0];
            gtc_pkg::CSR_SWIPE_MIN_DIST: swipe_min_in = csr_data[gtc_pkg::DIST_BITS-1:0];
            gtc_pkg::CSR_DRAG_MIN_DIST: drag_min_in = csr_data[gtc_pkg::DIST_BITS-1:0];
            gtc_pkg::CSR_LONG_PRESS_MS: long_press_in = csr_data[gtc_pkg::TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
      swipe_sq_in = {{gtc_pkg::DIST_BITS{1'b0}}, swipe_min_in}
                    * {{gtc_pkg::DIST_BITS{1'b0}}, swipe_min_in};
      drag_sq_in = {{gtc_pkg::DIST_BITS{1'b0}}, drag_min_in}
                   * {{gtc_pkg::DIST_BITS{1'b0}}, drag_min_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gtc_pkg::SCREEN_WIDTH_RESET;
         height_ff <= gtc_pkg::SCREEN_HEIGHT_RESET;
         swipe_min_ff <= gtc_pkg::SWIPE_MIN_RESET;
         drag_min_ff <= gtc_pkg::DRAG_MIN_RESET;
         long_press_ff <= gtc_pkg::LONG_PRESS_RESET;
         swipe_sq_ff <= gtc_pkg::SWIPE_SQ_RESET;
         drag_sq_ff <= gtc_pkg::DRAG_SQ_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         swipe_min_ff <= swipe_min_in;
         drag_min_ff <= drag_min_in;
         long_press_ff <= long_press_in;
         swipe_sq_ff <= swipe_sq_in;
         drag_sq_ff <= drag_sq_in;
      end
   end

   assign cfg.screen_width = width_ff;
   assign cfg.screen_height = height_ff;
   assign cfg.swipe_sq = swipe_sq_ff;
   assign cfg.drag_sq = drag_sq_ff;
   assign cfg.long_press = long_press_ff;

endmodule

// ===== sv/gtc_core.sv =====
// Gesture state and the single-pass classification of one event beat.
module gtc_core (
   input  logic                               clock,
   input  logic                               reset,
   input  gtc_pkg::cfg_type                   cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [1:0]                         req_tuser,
   input  logic [gtc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               room,
   output gtc_pkg::push_type                  push
);

   localparam int CB = gtc_pkg::COORD_BITS;

   logic [CB-1:0]                 start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [CB-1:0]                 last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic                          dragging_ff, dragging_in;
   logic                          fired_ff, fired_in;
   logic                          armed_ff, armed_in;
   logic [gtc_pkg::TIME_BITS-1:0] count_ff, count_in;

   logic                          accept;
   gtc_pkg::req_kind_type         kind;
   logic [CB-1:0]                 px, py, cur_x, cur_y, dx, dy;
   logic                          on_screen, lt_x, lt_y, far_drag;
   logic [gtc_pkg::SQ_BITS-1:0]   dx2, dy2;
   gtc_pkg::cmp_type              travel;
   gtc_pkg::swipe_dir_type        dir;

   function automatic gtc_pkg::result_type make_result(
      input gtc_pkg::event_kind_type k,
      input logic [CB-1:0] fx,
      input logic [CB-1:0] fy,
      input logic [CB-1:0] tx,
      input logic [CB-1:0] ty,
      input gtc_pkg::swipe_dir_type d,
      input logic l
   );
      gtc_pkg::result_type r;
      r.kind = k;
      r.from_x = fx;
      r.from_y = fy;
      r.to_x = tx;
      r.to_y = ty;
      r.dir = d;
      r.last = l;
      return r;
   endfunction

   assign accept = req_tvalid & room;
   assign req_tready = room;
   assign kind = gtc_pkg::req_kind_type'(req_tuser);
   assign px = req_tdata[CB-1:0];
   assign py = req_tdata[2*CB-1:CB];
   assign on_screen = ({1'b0, px} < cfg.screen_width) && ({1'b0, py} < cfg.screen_height);

   // A move is judged on its new point, a release on the last stored point.
   assign cur_x = (kind == gtc_pkg::REQ_MOVE) ? px : last_x_ff;
   assign cur_y = (kind == gtc_pkg::REQ_MOVE) ? py : last_y_ff;
   assign lt_x = cur_x < start_x_ff;
   assign lt_y = cur_y < start_y_ff;
   assign dx = lt_x ? start_x_ff - cur_x : cur_x - start_x_ff;
   assign dy = lt_y ? start_y_ff - cur_y : cur_y - start_y_ff;
   assign dx2 = {{CB{1'b0}}, dx} * {{CB{1'b0}}, dx};
   assign dy2 = {{CB{1'b0}}, dy} * {{CB{1'b0}}, dy};
   assign travel = gtc_pkg::cmp_type'(dx2) + gtc_pkg::cmp_type'(dy2);
   assign far_drag = travel >= gtc_pkg::cmp_type'(cfg.drag_sq);

   always_comb begin
      if (travel < gtc_pkg::cmp_type'(cfg.swipe_sq)) begin
         dir = gtc_pkg::DIR_NONE;
      end else if (gtc_pkg::cmp_type'(dx2) > (gtc_pkg::cmp_type'(dy2) << 2)) begin
         dir = lt_x ? gtc_pkg::DIR_LEFT : gtc_pkg::DIR_RIGHT;
      end else if (gtc_pkg::cmp_type'(dy2) > (gtc_pkg::cmp_type'(dx2) << 2)) begin
         dir = lt_y ? gtc_pkg::DIR_UP : gtc_pkg::DIR_DOWN;
      end else begin
         dir = gtc_pkg::DIR_NONE;
      end
   end

   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      dragging_in = dragging_ff;
      fired_in = fired_ff;
      armed_in = armed_ff;
      count_in = count_ff;
      push.count = 2'd0;
      push.first = make_result(gtc_pkg::EV_TAP, start_x_ff, start_y_ff, last_x_ff, last_y_ff,
                               gtc_pkg::DIR_NONE, 1'b1);
      push.second = push.first;
      if (accept) begin
         case (kind)
            gtc_pkg::REQ_DOWN: begin
               if (on_screen) begin
                  start_x_in = px;
                  start_y_in = py;
                  last_x_in = px;
                  last_y_in = py;
                  dragging_in = 1'b0;
                  fired_in = 1'b0;
                  armed_in = 1'b1;
                  count_in = cfg.long_press;
                  push.count = 2'd1;
                  push.first = make_result(gtc_pkg::EV_DOWN, px, py, px, py,
                                           gtc_pkg::DIR_NONE, 1'b1);
               end
            end
            gtc_pkg::REQ_MOVE: begin
               if (on_screen) begin
                  last_x_in = px;
                  last_y_in = py;
                  if (far_drag && !dragging_ff) begin
                     armed_in = 1'b0;
                     fired_in = 1'b0;
                     dragging_in = 1'b1;
                     push.count = 2'd2;
                     push.first = make_result(gtc_pkg::EV_CANCEL, start_x_ff, start_y_ff,
                                              px, py, gtc_pkg::DIR_NONE, 1'b0);
                     push.second = make_result(gtc_pkg::EV_MOVING, start_x_ff, start_y_ff,
                                               px, py, dir, 1'b1);
                  end else if (dragging_ff) begin
                     push.count = 2'd1;
                     push.first = make_result(gtc_pkg::EV_MOVING, start_x_ff, start_y_ff,
                                              px, py, dir, 1'b1);
                  end
               end
            end
            gtc_pkg::REQ_UP: begin
               armed_in = 1'b0;
               if (fired_ff) begin
                  fired_in = 1'b0;
               end else if (far_drag) begin
                  push.count = 2'd1;
                  push.first = make_result(gtc_pkg::EV_RELEASE, start_x_ff, start_y_ff,
                                           last_x_ff, last_y_ff, dir, 1'b1);
               end else if (dragging_ff) begin
                  push.count = 2'd1;
                  push.first = make_result(gtc_pkg::EV_CANCEL, start_x_ff, start_y_ff,
                                           last_x_ff, last_y_ff, gtc_pkg::DIR_NONE, 1'b1);
               end else begin
                  push.count = 2'd1;
               end
            end
            gtc_pkg::REQ_TICK: begin
               if (armed_ff) begin
                  if (count_ff <= gtc_pkg::TIME_BITS'(1)) begin
                     count_in = '0;
                     armed_in = 1'b0;
                     fired_in = 1'b1;
                     push.count = 2'd1;
                     push.first = make_result(gtc_pkg::EV_LONG, start_x_ff, start_y_ff,
                                              last_x_ff, last_y_ff, gtc_pkg::DIR_NONE, 1'b1);
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         dragging_ff <= 1'b0;
         fired_ff <= 1'b0;
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         dragging_ff <= dragging_in;
         fired_ff <= fired_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

   a_armed_fired_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(armed_ff && fired_ff))
      else $error("long press armed and fired together");

   a_drag_disarms: assert property (@(posedge clock) disable iff (reset)
      dragging_ff |-> !armed_ff)
      else $error("long press still armed during a drag");

   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.kind == gtc_pkg::EV_CANCEL
         && push.second.kind == gtc_pkg::EV_MOVING && !push.first.last && push.second.last))
      else $error("two results that are not cancel then moving");

endmodule

// ===== sv/gtc_rsp_fifo.sv =====
// Three-entry result queue that takes up to two results a cycle and gives one a beat.
module gtc_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  gtc_pkg::push_type                  push,
   output logic                               room,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gtc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int DEPTH = 3;

   gtc_pkg::result_type mem_ff [DEPTH];
   gtc_pkg::result_type head;
   logic [1:0]          rd_ptr_ff, rd_ptr_in;
   logic [1:0]          wr_ptr_ff, wr_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic [1:0]          wr_next;
   logic                pop;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
   endfunction

   assign pop = rsp_tvalid & rsp_tready;
   assign room = (count_ff <= 2'd1) || (count_ff == 2'd2 && pop);
   assign wr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1: wr_ptr_in = wr_next;
         2'd2: wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = 2'(3'(count_ff) + 3'(push.count) - 3'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata = gtc_pkg::rsp_data_type'({head.dir, head.to_y, head.to_x,
                                                head.from_y, head.from_x});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (3'(count_ff) + 3'(push.count) <= 3'(DEPTH) + 3'(pop)))
      else $error("result queue overflow");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("result queue count lost a beat");

endmodule

// ===== sv/touch_gesture_classifier_top.sv =====
// Top level of the touch gesture classifier.
//
// Event beats arrive on the req channel: tuser holds the event type (down, move,
// up, millisecond tick) and tdata the touch point. Each accepted beat is
// classified in the cycle it is taken, against the gesture state, and its zero,
// one or two result beats enter a three-entry queue that drives the rsp channel.
// The first result of a beat is offered on rsp in the following cycle if the
// queue was empty; tlast marks the final result belonging to one event beat.
// One event beat is accepted per cycle while the queue has space for two more
// results, as it does while rsp drains one beat per cycle and no beat yields
// two results; a move that starts a drag yields two results, and if the queue
// already holds two results the extra beat makes req_tready fall until rsp
// drains it. When the receiver stalls, the queue fills and req_tready falls
// until space returns; nothing is dropped.
// Registers are written through the csr channel, which is always ready; a write
// takes effect for the event beat accepted in the following cycle. Write them
// only while no event beat is in flight.
// Reset clears the gesture state and the queue and restores register defaults.
module touch_gesture_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: req_type.
   input  logic [1:0]                          req_tuser,
   // Fields from bit 0: pos_x, pos_y.
   input  logic [gtc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: event_kind.
   output logic [2:0]                          rsp_tuser,
   // Fields from bit 0: from_x, from_y, to_x, to_y, swipe_dir, zero padding.
   output logic [gtc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gtc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gtc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   gtc_pkg::cfg_type  cfg;
   gtc_pkg::push_type push;
   logic              room;

   gtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gtc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .room       (room),
      .push       (push)
   );

   gtc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
